// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, clocked on the rising edge with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PRIT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check the consequent in the cycle after the antecedent.
`define PRIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/prit_pkg.sv -----
package prit_pkg;

  localparam int RAM_DEPTH = 64;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int IDX_W     = 6;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 32;
  localparam int LATCH_W = 17;
  localparam int PER_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // 0x3400-0x347F window, bit 6 selects the scratch RAM half
  localparam logic [8:0] WIN_TAG = 9'h068;

  localparam logic [ADDR_W-1:0] REG_CTRL      = 16'h3401;
  localparam logic [ADDR_W-1:0] REG_LATCH_LO  = 16'h3402;
  localparam logic [ADDR_W-1:0] REG_LATCH_HI  = 16'h3403;
  localparam logic [ADDR_W-1:0] REG_PERIOD_LO = 16'h3410;
  localparam logic [ADDR_W-1:0] REG_PERIOD_HI = 16'h3411;

  // period * 178684 / 100000 == ((period * 44671) >> 3) / 3125
  localparam int PER_MUL_W = 16;
  localparam logic [PER_MUL_W-1:0] PER_MUL = 16'd44671;
  localparam int PROD_W   = 32;
  localparam int Y_W      = PROD_W - 3;
  localparam int RECIP_SH = 29;
  localparam int RECIP_W  = 18;
  localparam logic [RECIP_W-1:0] RECIP = 18'd171798;   // floor(2^29 / 3125)
  localparam int WIDE_W   = Y_W + RECIP_W;
  localparam int Q_W      = WIDE_W - RECIP_SH;
  localparam logic [11:0] DIVISOR = 12'd3125;

endpackage

// ----- src/prit_if.sv -----
interface prit_in_if;
  logic                         valid;
  logic                         ready;
  logic [prit_pkg::OP_W-1:0]    op;
  logic [prit_pkg::ADDR_W-1:0]  bus_address;
  logic [prit_pkg::DATA_W-1:0]  write_value;

  modport source (output valid, op, bus_address, write_value, input ready);
  modport sink   (input valid, op, bus_address, write_value, output ready);
endinterface

interface prit_out_if;
  logic                         valid;
  logic                         ready;
  logic [prit_pkg::DATA_W-1:0]  read_value;
  logic                         claimed;
  logic                         irq_line;

  modport source (output valid, read_value, claimed, irq_line, input ready);
  modport sink   (input valid, read_value, claimed, irq_line, output ready);
endinterface

// ----- src/prit_ram.sv -----
module prit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/prit_reload_div.sv -----
module prit_reload_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [prit_pkg::PER_W-1:0]   period,
  output logic                         busy,
  output logic                         done,
  output logic [prit_pkg::LATCH_W-1:0] result
);

  logic                          v1_r, v2_r;
  logic [prit_pkg::PROD_W-1:0]   x_r;
  logic [prit_pkg::Y_W-1:0]      y_r;
  logic [prit_pkg::WIDE_W-1:0]   wide_r;
  logic [prit_pkg::Y_W-1:0]      y_nxt;
  logic [prit_pkg::Q_W-1:0]      q_est;
  logic [prit_pkg::Y_W-1:0]      back;
  logic [prit_pkg::Y_W-1:0]      rem;
  logic [prit_pkg::Q_W-1:0]      q_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  assign y_nxt = x_r[prit_pkg::PROD_W-1:3];

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= prit_pkg::PROD_W'(period) * prit_pkg::PROD_W'(prit_pkg::PER_MUL);
    end
    if (v1_r) begin
      y_r    <= y_nxt;
      wide_r <= prit_pkg::WIDE_W'(y_nxt) * prit_pkg::WIDE_W'(prit_pkg::RECIP);
    end
  end

  // Estimate is exact or one short; fix with a single compare
  assign q_est = wide_r[prit_pkg::WIDE_W-1:prit_pkg::RECIP_SH];
  assign back  = prit_pkg::Y_W'(q_est) * prit_pkg::Y_W'(prit_pkg::DIVISOR);
  assign rem   = y_r - back;
  assign q_fin = (rem >= prit_pkg::Y_W'(prit_pkg::DIVISOR)) ? q_est + 1'b1 : q_est;

  assign busy   = v1_r | v2_r;
  assign done   = v2_r;
  assign result = q_fin[prit_pkg::LATCH_W-1:0];

endmodule

// ----- src/play_rate_irq_timer_registers_top.sv -----
// Interrupt timer with a 64-byte scratch RAM behind a bus window at 0x3400-0x347F. Each
// transaction is a bus read, a bus write, one CPU clock tick or a no-op, and yields
// exactly one result in the cycle after it is taken, so the block sustains one
// transaction per cycle while the output is not held off. The one exception is a write
// to the play period (0x3410/0x3411): the reload latch is rebuilt by a three-stage
// multiply-and-reciprocal pipeline, and input is held off while it runs. The scratch
// RAM is a registered-read memory whose read data is muxed straight onto the result
// output; per-entry valid bits make it read as zero after reset, so no clearing pass is needed.
module play_rate_irq_timer_registers_top (
  input  logic         clk,
  input  logic         rst_n,
  prit_in_if.sink      in_ch,
  prit_out_if.source   out_ch
);

  logic                          en_r, en_nxt;
  logic                          irq_r, irq_nxt;
  logic [prit_pkg::LATCH_W-1:0]  reload_r, reload_nxt;
  logic [prit_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [prit_pkg::PER_W-1:0]    period_r, period_nxt;
  logic [prit_pkg::RAM_DEPTH-1:0] vld_r;

  logic                          out_valid_r;
  logic [prit_pkg::DATA_W-1:0]   rv_r, rv_nxt;
  logic                          claimed_r, claimed_nxt;
  logic                          ram_sel_r, ram_sel_nxt;

  logic                          accept;
  logic                          in_win, ram_half, ram_hit;
  logic [prit_pkg::IDX_W-1:0]    idx;
  logic [prit_pkg::RAM_AW-1:0]   ram_addr;
  logic                          ram_we, ram_re;
  logic [prit_pkg::DATA_W-1:0]   ram_rdata;
  logic                          div_start, div_busy, div_done;
  logic [prit_pkg::LATCH_W-1:0]  div_result;
  prit_pkg::op_t                 op;

  assign op       = prit_pkg::op_t'(in_ch.op);
  assign in_win   = (in_ch.bus_address[prit_pkg::ADDR_W-1:7] == prit_pkg::WIN_TAG);
  assign ram_half = in_ch.bus_address[6];
  assign idx      = in_ch.bus_address[prit_pkg::IDX_W-1:0];
  assign ram_hit  = in_win && ram_half && (32'(idx) < prit_pkg::RAM_DEPTH);
  assign ram_addr = idx[prit_pkg::RAM_AW-1:0];

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready) && !div_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ram_we = accept && (op == prit_pkg::OP_WRITE) && ram_hit;
  assign ram_re = accept && (op == prit_pkg::OP_READ) && ram_hit;

  always_comb begin
    en_nxt      = en_r;
    irq_nxt     = irq_r;
    reload_nxt  = reload_r;
    cnt_nxt     = cnt_r;
    period_nxt  = period_r;
    div_start   = 1'b0;
    rv_nxt      = '0;
    claimed_nxt = 1'b0;
    ram_sel_nxt = 1'b0;

    if (div_done) begin
      reload_nxt = div_result;
    end

    if (accept) begin
      unique case (op)
        prit_pkg::OP_READ: begin
          claimed_nxt = in_win;
          ram_sel_nxt = ram_hit && vld_r[ram_addr];
          if (in_win && (in_ch.bus_address == prit_pkg::REG_CTRL)) begin
            irq_nxt = 1'b0;
            rv_nxt  = prit_pkg::DATA_W'(en_r);
          end
        end
        prit_pkg::OP_WRITE: begin
          claimed_nxt = in_win;
          if (in_win && !ram_half) begin
            unique case (in_ch.bus_address)
              prit_pkg::REG_CTRL: begin
                en_nxt  = in_ch.write_value[0];
                irq_nxt = 1'b0;
                if (in_ch.write_value[0]) begin
                  cnt_nxt = prit_pkg::CNT_W'(reload_r);
                end
              end
              prit_pkg::REG_LATCH_LO: begin
                reload_nxt = {1'b0, reload_r[15:8], in_ch.write_value};
              end
              prit_pkg::REG_LATCH_HI: begin
                reload_nxt = {1'b0, in_ch.write_value, reload_r[7:0]};
              end
              prit_pkg::REG_PERIOD_LO: begin
                period_nxt = {period_r[15:8], in_ch.write_value};
                div_start  = 1'b1;
              end
              prit_pkg::REG_PERIOD_HI: begin
                period_nxt = {in_ch.write_value, period_r[7:0]};
                div_start  = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        prit_pkg::OP_TICK: begin
          if (en_r) begin
            // reaching zero reloads in the same step
            if (cnt_r == prit_pkg::CNT_W'(1)) begin
              cnt_nxt = prit_pkg::CNT_W'(reload_r);
              irq_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        prit_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      irq_r       <= 1'b0;
      reload_r    <= '0;
      cnt_r       <= '0;
      period_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      en_r     <= en_nxt;
      irq_r    <= irq_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
      if (ram_we) begin
        vld_r[ram_addr] <= 1'b1;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next transaction is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      rv_r      <= rv_nxt;
      claimed_r <= claimed_nxt;
      ram_sel_r <= ram_sel_nxt;
    end
  end

  prit_ram #(
    .WIDTH (prit_pkg::DATA_W),
    .DEPTH (prit_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_ch.write_value),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  prit_reload_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .period (period_nxt),
    .busy   (div_busy),
    .done   (div_done),
    .result (div_result)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = ram_sel_r ? ram_rdata : rv_r;
  assign out_ch.claimed    = claimed_r;
  assign out_ch.irq_line   = irq_r;

endmodule

// ----- src/prit_checker.sv -----
`include "assert_macros.svh"

module prit_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [prit_pkg::OP_W-1:0]    in_op,
  input logic [prit_pkg::ADDR_W-1:0]  in_bus_address,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [prit_pkg::DATA_W-1:0]  out_read_value,
  input logic                         out_claimed
);

  logic in_take;
  logic out_win;

  assign in_take = in_valid && in_ready;
  assign out_win = (in_bus_address[prit_pkg::ADDR_W-1:7] == prit_pkg::WIN_TAG);

  `PRIT_ASSERT_NEXT(a_take_gives_result, clk, rst_n, in_take, out_valid)
  `PRIT_ASSERT_NEXT(a_tick_unclaimed, clk, rst_n,
    in_take && (in_op == prit_pkg::OP_TICK), !out_claimed && (out_read_value == '0))
  `PRIT_ASSERT_NEXT(a_outside_unclaimed, clk, rst_n,
    in_take && !out_win, !out_claimed && (out_read_value == '0))
  `PRIT_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_read_value))
  `PRIT_ASSERT_SAME(a_no_take_when_full, clk, rst_n, out_valid && !out_ready, !in_ready)

endmodule

bind play_rate_irq_timer_registers_top prit_checker u_prit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .in_bus_address (in_ch.bus_address),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_claimed    (out_ch.claimed)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import prit_pkg::*;

  localparam int unsigned RANDOM_WORK = 1450;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  localparam logic [ADDR_W-1:0] WIN_LO   = 16'h3400;
  localparam logic [ADDR_W-1:0] WIN_HI   = 16'h347F;
  localparam logic [ADDR_W-1:0] RAM_BASE = 16'h3440;
  localparam logic [ADDR_W-1:0] REG_SPARE = 16'h3405;
  localparam logic [ADDR_W-1:0] REG_HOLE  = 16'h3420;
  localparam logic [63:0] TICKS_PER_US_NUM = 64'd178684;
  localparam logic [63:0] TICKS_PER_US_DEN = 64'd100000;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              claimed;
    logic              irq_line;
  } resp_t;

  typedef struct {
    bus_item_t item;
    bit        typed;
    resp_t     resp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  prit_in_if  in_ch ();
  prit_out_if out_ch ();

  play_rate_irq_timer_registers_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timer image
  logic              tmr_en;
  logic [LATCH_W-1:0] latch;
  logic [CNT_W-1:0]  down_cnt;
  logic [PER_W-1:0]  period_us;
  logic              irq_q;
  logic [DATA_W-1:0] ram_img [RAM_DEPTH];

  resp_t responses_due [$];

  int unsigned sent_total;
  int unsigned work_items;
  int unsigned responses_seen;
  int unsigned timer_fires;
  int unsigned mismatches;
  int unsigned send_calm;
  int unsigned recv_calm;
  bit          long_hold_req;
  bit          hold_active;

  function automatic logic [LATCH_W-1:0] period_to_ticks(logic [PER_W-1:0] p);
    logic [63:0] wide;
    wide = (64'(p) * TICKS_PER_US_NUM) / TICKS_PER_US_DEN;
    return wide[LATCH_W-1:0];
  endfunction

  // Advance the timer image by one transaction and return the bus response.
  function automatic resp_t bus_response(bus_item_t it);
    resp_t r;
    logic  in_win;
    logic [5:0] idx;
    r      = '0;
    in_win = (it.addr >= WIN_LO) && (it.addr <= WIN_HI);
    idx    = it.addr[5:0];
    case (it.op)
      OP_READ: if (in_win) begin
        r.claimed = 1'b1;
        if (it.addr >= RAM_BASE) begin
          if (int'(idx) < RAM_DEPTH) r.read_value = ram_img[idx];
        end else if (it.addr == REG_CTRL) begin
          irq_q        = 1'b0;
          r.read_value = {7'd0, tmr_en};
        end
      end
      OP_WRITE: if (in_win) begin
        r.claimed = 1'b1;
        if (it.addr >= RAM_BASE) begin
          if (int'(idx) < RAM_DEPTH) ram_img[idx] = it.data;
        end else begin
          case (it.addr)
            REG_CTRL: begin
              tmr_en = it.data[0];
              if (tmr_en) down_cnt = CNT_W'(latch);
              irq_q = 1'b0;
            end
            REG_LATCH_LO: latch = {1'b0, latch[15:8], it.data};
            REG_LATCH_HI: latch = {1'b0, it.data, latch[7:0]};
            REG_PERIOD_LO: begin
              period_us = {period_us[15:8], it.data};
              latch     = period_to_ticks(period_us);
            end
            REG_PERIOD_HI: begin
              period_us = {it.data, period_us[7:0]};
              latch     = period_to_ticks(period_us);
            end
            default: ;
          endcase
        end
      end
      OP_TICK: if (tmr_en) begin
        down_cnt = down_cnt - 1'b1;
        if (down_cnt == '0) begin
          down_cnt = CNT_W'(latch);
          irq_q    = 1'b1;
          timer_fires++;
        end
      end
      default: ;
    endcase
    r.irq_line = irq_q;
    return r;
  endfunction

  // Idle length per transaction, with occasional runs of back-to-back traffic.
  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send(input op_t op, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                      input bit typed = 1'b0, input resp_t given = '0);
    int unsigned gap;
    bus_item_t   it;
    resp_t       r;
    gap = draw_gap(send_calm);
    // keep the input busy while the receiver is held off
    if (long_hold_req || hold_active) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.bus_address <= a;
    in_ch.write_value <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    it = '{op: op, addr: a, data: d};
    r  = bus_response(it);
    responses_due.push_back(typed ? given : r);
    sent_total++;
    if (op == OP_TICK || ((op == OP_READ || op == OP_WRITE) && a >= WIN_LO && a <= WIN_HI))
      work_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  function automatic dir_row_t mk_row(op_t op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                      bit typed = 1'b0, logic [DATA_W-1:0] rv = '0,
                                      logic cl = 1'b0, logic irq = 1'b0);
    dir_row_t row;
    row.item  = '{op: op, addr: a, data: d};
    row.typed = typed;
    row.resp  = '{read_value: rv, claimed: cl, irq_line: irq};
    return row;
  endfunction

  task automatic rand_noise();
    send(op_t'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 16'hFFFF)),
         DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic rand_window();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 3))
      0:       a = REG_CTRL + ADDR_W'($urandom_range(0, 2));
      1:       a = REG_PERIOD_LO + ADDR_W'($urandom_range(0, 1));
      default: a = ADDR_W'($urandom_range(WIN_LO, WIN_HI));
    endcase
    send($urandom_range(0, 1) ? OP_WRITE : OP_READ, a, DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic ram_access();
    send($urandom_range(0, 1) ? OP_WRITE : OP_READ,
         RAM_BASE + ADDR_W'($urandom_range(0, 63)), DATA_W'($urandom_range(0, 255)));
  endtask

  // Load a short period or a small reload latch, usually arm the timer and let it run through a few expiries.
  task automatic timer_run();
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 2) == 0) begin
      send(OP_WRITE, REG_PERIOD_LO, DATA_W'($urandom_range(0, 9)));
      send(OP_WRITE, REG_PERIOD_HI, 8'h00);
    end else begin
      send(OP_WRITE, REG_LATCH_LO, DATA_W'($urandom_range(0, 15)));
      send(OP_WRITE, REG_LATCH_HI,
           ($urandom_range(0, 7) == 0) ? DATA_W'($urandom_range(0, 255)) : 8'h00);
    end
    send(OP_WRITE, REG_CTRL, ($urandom_range(0, 5) == 0) ? DATA_W'($urandom_range(0, 255))
                                                      : DATA_W'($urandom_range(0, 255) | 1));
    n = $urandom_range(1, 48);
    repeat (n) begin
      k = $urandom_range(0, 11);
      if (k == 0) send(OP_READ, REG_CTRL, DATA_W'($urandom_range(0, 255)));
      else if (k == 1) ram_access();
      else if (k == 2) rand_noise();
      else send(OP_TICK, ADDR_W'($urandom_range(0, 16'hFFFF)), DATA_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // stimulus
  initial begin
    dir_row_t dir_rows [$];
    bit hold_done;
    bit drain_done;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_NOP;
    in_ch.bus_address <= '0;
    in_ch.write_value <= '0;
    tmr_en    = 1'b0;
    latch     = '0;
    down_cnt  = '0;
    period_us = '0;
    irq_q     = 1'b0;
    foreach (ram_img[i]) ram_img[i] = '0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    dir_rows.push_back(mk_row(OP_READ,  REG_CTRL,  8'h00, 1, 8'h00, 1, 0));
    dir_rows.push_back(mk_row(OP_READ,  RAM_BASE,  8'h00, 1, 8'h00, 1, 0));
    dir_rows.push_back(mk_row(OP_READ,  WIN_HI,    8'h00, 1, 8'h00, 1, 0));
    dir_rows.push_back(mk_row(OP_READ,  16'h33FF,  8'h00, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_READ,  16'h3480,  8'h00, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_WRITE, 16'hFFFF,  8'hFF, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_READ,  16'h0000,  8'h00, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_TICK,  REG_CTRL,  8'hFF, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_NOP,   RAM_BASE,  8'hFF, 1, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(OP_WRITE, RAM_BASE,  8'hFF, 1, 8'h00, 1, 0));
    dir_rows.push_back(mk_row(OP_WRITE, WIN_HI,    8'h5A));
    dir_rows.push_back(mk_row(OP_READ,  RAM_BASE,  8'h00, 1, 8'hFF, 1, 0));
    dir_rows.push_back(mk_row(OP_READ,  WIN_HI,    8'h00));
    dir_rows.push_back(mk_row(OP_WRITE, REG_SPARE, 8'hAB, 1, 8'h00, 1, 0));
    dir_rows.push_back(mk_row(OP_READ,  REG_HOLE,  8'h00, 1, 8'h00, 1, 0));
    // reload of one: arm, expire, acknowledge
    dir_rows.push_back(mk_row(OP_WRITE, REG_LATCH_LO, 8'h01));
    dir_rows.push_back(mk_row(OP_WRITE, REG_LATCH_HI, 8'h00));
    dir_rows.push_back(mk_row(OP_WRITE, REG_CTRL,     8'h01));
    dir_rows.push_back(mk_row(OP_TICK,  16'h0000,     8'h00));
    dir_rows.push_back(mk_row(OP_READ,  REG_CTRL,     8'h00));
    // zero reload, then a tick on an empty counter wraps it
    dir_rows.push_back(mk_row(OP_WRITE, REG_LATCH_LO, 8'h00));
    dir_rows.push_back(mk_row(OP_TICK,  16'h0000,     8'h00));
    dir_rows.push_back(mk_row(OP_TICK,  16'h0000,     8'h00));
    dir_rows.push_back(mk_row(OP_WRITE, REG_CTRL,     8'h00));
    dir_rows.push_back(mk_row(OP_WRITE, REG_PERIOD_LO, 8'hFF));
    dir_rows.push_back(mk_row(OP_WRITE, REG_PERIOD_HI, 8'hFF));
    dir_rows.push_back(mk_row(OP_WRITE, REG_CTRL,     8'hFE));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].item.op, dir_rows[i].item.addr, dir_rows[i].item.data,
           dir_rows[i].typed, dir_rows[i].resp);
    drain();
    work_items = 0;

    while (sent_total < RANDOM_WORK) begin
      if (!hold_done && sent_total > 450) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!drain_done && sent_total > 950) begin
        drain();
        drain_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:       rand_noise();
        1, 2:    rand_window();
        3: begin
          send(OP_WRITE, REG_PERIOD_LO, DATA_W'($urandom_range(0, 255)));
          send(OP_WRITE, REG_PERIOD_HI, DATA_W'($urandom_range(0, 255)));
        end
        4:       ram_access();
        default: timer_run();
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (responses_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d responses never arrived", $time, responses_due.size());
    end
    $display("tb_top: %0d transactions (%0d in window or ticks), %0d responses checked",
             sent_total, work_items, responses_seen);
    $display("tb_top: timer expired %0d times, %0d mismatches", timer_fires, mismatches);
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // response side
  initial begin
    int unsigned stall;
    resp_t want;
    resp_t got;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        hold_active   = 1'b1;
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = '{read_value: out_ch.read_value, claimed: out_ch.claimed,
              irq_line: out_ch.irq_line};
      responses_seen++;
      if (responses_due.size() == 0) begin
        mismatches++;
        $display("%0t: response with nothing outstanding, expected none, got %0h", $time, got);
      end else begin
        want = responses_due.pop_front();
        if (got.read_value !== want.read_value)
          report("read_value", want.read_value, got.read_value);
        if (got.claimed !== want.claimed) report("claimed", 8'(want.claimed), 8'(got.claimed));
        if (got.irq_line !== want.irq_line)
          report("irq_line", 8'(want.irq_line), 8'(got.irq_line));
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule
